@@ hw/rtl/kab_pkg.sv @@
// Package for the angle/bias Kalman filter: register map, reset values,
// shared-unit request/response structs and saturation helpers. No dependencies.
package kab_pkg;

  localparam int unsigned PADDR_W = 4;

  localparam logic [1:0] REG_Q_ANGLE = 2'd0;
  localparam logic [1:0] REG_Q_BIAS  = 2'd1;
  localparam logic [1:0] REG_R_MEAS  = 2'd2;

  localparam logic [31:0] Q_ANGLE_RST = 32'd4294967;
  localparam logic [31:0] Q_BIAS_RST  = 32'd12884902;
  localparam logic [31:0] R_MEAS_RST  = 32'd128849019;

  typedef struct packed {
    logic [31:0] q_angle;
    logic [31:0] q_bias;
    logic [31:0] r_meas;
  } kab_cfg_t;

  typedef struct packed {
    logic               start;
    logic               is_div;
    logic               sh32;
    logic signed [63:0] a;
    logic signed [63:0] b;
  } kab_mdu_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] res;
  } kab_mdu_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v[65:31] == {35{v[65]}}) begin
      return v[31:0];
    end
    return v[65] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [65:0] v);
    if (v[65:47] == {19{v[65]}}) begin
      return v[47:0];
    end
    return v[65] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
  endfunction

endpackage

@@ hw/rtl/kab_item_if.sv @@
// Input channel of the angle/bias Kalman filter: valid/ready plus sample word.
// No dependencies.
interface kab_item_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] measured_angle;
  logic signed [31:0] measured_rate;
  logic        [15:0] time_step;

  modport source (output valid, measured_angle, measured_rate, time_step, input ready);
  modport sink   (input valid, measured_angle, measured_rate, time_step, output ready);
endinterface

@@ hw/rtl/kab_result_if.sv @@
// Output channel of the angle/bias Kalman filter: valid/ready plus angle word.
// No dependencies.
interface kab_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] filtered_angle;

  modport source (output valid, filtered_angle, input ready);
  modport sink   (input valid, filtered_angle, output ready);
endinterface

@@ hw/rtl/kalman_angle_bias_filter_top.sv @@
// Top level of the two-state angle/gyro-bias Kalman filter.
// Depends on kab_pkg, kab_item_if, kab_result_if, kab_regs, kab_mdu, kab_core.
//
// Usage:
//   item_i carries one sample word per handshake: measured angle and rate
//   (signed Q16.16) and the time step (unsigned Q0.16). result_o returns one
//   word per sample, the corrected angle (signed Q16.16, saturated).
//   The APB port sets the angle and bias process noise and the measurement
//   noise (unsigned Q0.32) at byte addresses 0, 4 and 8; write only while idle.
// Sequencing:
//   Every product and both gain quotients go through one shared unit, which
//   works through a multiply in 16-bit digits and a division one quotient bit a cycle.
//   The divisions are skipped when the innovation variance is zero.
//   item_i.ready is high only while the filter waits for a sample, so one
//   sample is in flight at a time and a new one is taken only once the last
//   one has been through the whole sequence.
// Reset clears angle, bias and covariance to zero and loads the default noise
// settings. A stalled result holds in the output register; the next sample
// is taken meanwhile and finishes once that register is free.
module kalman_angle_bias_filter_top import kab_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  kab_item_if.sink           item_i,
  kab_result_if.source       result_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  kab_cfg_t     cfg;
  kab_mdu_req_t mdu_req;
  kab_mdu_rsp_t mdu_rsp;

  kab_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  kab_mdu u_mdu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mdu_req),
    .rsp_o  (mdu_rsp)
  );

  kab_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .item_i   (item_i),
    .result_o (result_o),
    .req_o    (mdu_req),
    .rsp_i    (mdu_rsp)
  );

endmodule

@@ hw/rtl/kab_regs.sv @@
// APB register file for the three noise settings.
// Depends on kab_pkg.
module kab_regs import kab_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output kab_cfg_t           cfg_o
);

  kab_cfg_t cfg_q;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.q_angle <= Q_ANGLE_RST;
      cfg_q.q_bias  <= Q_BIAS_RST;
      cfg_q.r_meas  <= R_MEAS_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_Q_ANGLE: cfg_q.q_angle <= pwdata;
        REG_Q_BIAS:  cfg_q.q_bias  <= pwdata;
        REG_R_MEAS:  cfg_q.r_meas  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_Q_ANGLE: prdata = cfg_q.q_angle;
      REG_Q_BIAS:  prdata = cfg_q.q_bias;
      REG_R_MEAS:  prdata = cfg_q.r_meas;
      default:     prdata = '0;
    endcase
  end

endmodule

@@ hw/rtl/kab_mdu.sv @@
// Shared multiply/divide unit: 64x16 digit-serial multiply with floor shift
// and clamp, and 80-step restoring Q32 division with saturation. Depends on kab_pkg.
module kab_mdu import kab_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  kab_mdu_req_t req_i,
  output kab_mdu_rsp_t rsp_o
);

  typedef enum logic [2:0] {MD_IDLE, MD_MUL, MD_MFIN, MD_DIV, MD_DFIN} md_state_e;

  localparam logic [127:0] MAG_LIM = 128'd1 << 62;
  localparam logic [79:0]  DIV_LIM = (80'd1 << 47) - 80'd1;

  md_state_e          state_q;
  logic               sh32_q;
  logic               neg_q;
  logic [63:0]        ma_q;
  logic [63:0]        mb_q;
  logic [127:0]       acc_q;
  logic [6:0]         cnt_q;
  logic [63:0]        rem_q;
  logic [79:0]        quo_q;
  logic [79:0]        dvd_q;
  logic               done_q;
  logic signed [63:0] res_q;

  logic [63:0]  ma_w;
  logic [63:0]  mb_w;
  logic [79:0]  part_w;
  logic [127:0] rnd_w;
  logic [127:0] q_w;
  logic [63:0]  qc_w;
  logic [64:0]  r2_w;
  logic         ge_w;
  logic         dsat_w;
  logic [63:0]  dmag_w;

  assign ma_w   = req_i.a[63] ? 64'(-req_i.a) : 64'(req_i.a);
  assign mb_w   = req_i.b[63] ? 64'(-req_i.b) : 64'(req_i.b);
  assign part_w = 80'(ma_q) * 80'(mb_q[{cnt_q[1:0], 4'b0} +: 16]);

  always_comb begin
    rnd_w = acc_q;
    if (neg_q) begin
      rnd_w = acc_q + (sh32_q ? 128'h0FFFF_FFFF : 128'h0FFFF);
    end
    q_w  = sh32_q ? (rnd_w >> 32) : (rnd_w >> 16);
    qc_w = (q_w > MAG_LIM) ? MAG_LIM[63:0] : q_w[63:0];
  end

  assign r2_w   = {rem_q, dvd_q[79]};
  assign ge_w   = r2_w >= {1'b0, mb_q};
  assign dsat_w = quo_q > DIV_LIM;
  assign dmag_w = dsat_w ? (neg_q ? 64'd1 << 47 : 64'(DIV_LIM)) : quo_q[63:0];

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      done_q  <= 1'b0;
      sh32_q  <= 1'b0;
      neg_q   <= 1'b0;
      ma_q    <= '0;
      mb_q    <= '0;
      acc_q   <= '0;
      cnt_q   <= '0;
      rem_q   <= '0;
      quo_q   <= '0;
      dvd_q   <= '0;
      res_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        MD_IDLE: begin
          if (req_i.start) begin
            neg_q  <= req_i.a[63] ^ req_i.b[63];
            sh32_q <= req_i.sh32;
            ma_q   <= ma_w;
            mb_q   <= mb_w;
            acc_q  <= '0;
            rem_q  <= '0;
            quo_q  <= '0;
            dvd_q  <= {ma_w[47:0], 32'b0};
            if (req_i.is_div) begin
              cnt_q   <= 7'd79;
              state_q <= MD_DIV;
            end else begin
              cnt_q   <= 7'd3;
              state_q <= MD_MUL;
            end
          end
        end
        MD_MUL: begin
          acc_q <= (acc_q << 16) + 128'(part_w);
          cnt_q <= cnt_q - 7'd1;
          if (cnt_q == 7'd0) begin
            state_q <= MD_MFIN;
          end
        end
        MD_MFIN: begin
          res_q   <= neg_q ? -$signed(qc_w) : $signed(qc_w);
          done_q  <= 1'b1;
          state_q <= MD_IDLE;
        end
        MD_DIV: begin
          dvd_q <= dvd_q << 1;
          if (ge_w) begin
            rem_q <= 64'(r2_w - {1'b0, mb_q});
            quo_q <= {quo_q[78:0], 1'b1};
          end else begin
            rem_q <= r2_w[63:0];
            quo_q <= {quo_q[78:0], 1'b0};
          end
          cnt_q <= cnt_q - 7'd1;
          if (cnt_q == 7'd0) begin
            state_q <= MD_DFIN;
          end
        end
        MD_DFIN: begin
          res_q   <= neg_q ? -$signed(dmag_w) : $signed(dmag_w);
          done_q  <= 1'b1;
          state_q <= MD_IDLE;
        end
        default: state_q <= MD_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/kab_core.sv @@
// Sequencer and state of the angle/bias Kalman filter; issues every product
// and quotient to the shared unit. Depends on kab_pkg and the channel interfaces.
module kab_core import kab_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kab_cfg_t            cfg_i,
  kab_item_if.sink            item_i,
  kab_result_if.source        result_o,
  output kab_mdu_req_t        req_o,
  input  kab_mdu_rsp_t        rsp_i
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_RATE, ST_PRED_M, ST_PRED_T, ST_PRED_QB, ST_GAIN_S, ST_DIV_K0,
    ST_DIV_K1, ST_COR_A, ST_COR_B, ST_COV_BA, ST_COV_BB, ST_COV_AA, ST_COV_AB,
    ST_OUT
  } state_e;

  state_e             state_q;
  logic               issued_q;
  logic signed [31:0] z_q;
  logic signed [31:0] w_q;
  logic        [15:0] dt_q;
  logic signed [31:0] ang_q;
  logic signed [31:0] bias_q;
  logic signed [47:0] paa_q;
  logic signed [47:0] pab_q;
  logic signed [47:0] pba_q;
  logic signed [47:0] pbb_q;
  logic signed [63:0] m_q;
  logic signed [63:0] s_q;
  logic signed [47:0] k0_q;
  logic signed [47:0] k1_q;
  logic signed [32:0] y_q;
  logic               out_vld_q;
  logic signed [31:0] out_ang_q;

  logic signed [31:0] rate_w;
  logic signed [65:0] t_w;
  logic signed [65:0] s_w;
  logic signed [65:0] res_w;
  logic               op_w;

  assign rate_w = sat32(66'(w_q) - 66'(bias_q));
  assign t_w    = 66'(m_q) - 66'(pab_q) - 66'(pba_q) + $signed(66'(cfg_i.q_angle));
  assign s_w    = 66'(paa_q) + $signed(66'(cfg_i.r_meas));
  assign res_w  = 66'(rsp_i.res);

  assign item_i.ready            = (state_q == ST_IDLE);
  assign result_o.valid          = out_vld_q;
  assign result_o.filtered_angle = out_ang_q;

  always_comb begin
    op_w       = 1'b1;
    req_o.is_div = 1'b0;
    req_o.sh32   = 1'b0;
    req_o.a      = '0;
    req_o.b      = '0;
    case (state_q)
      ST_RATE:    begin req_o.a = 64'(dt_q); req_o.b = 64'(rate_w); end
      ST_PRED_M:  begin req_o.a = 64'(dt_q); req_o.b = 64'(pbb_q); end
      ST_PRED_T:  begin req_o.a = 64'(dt_q); req_o.b = $signed(t_w[63:0]); end
      ST_PRED_QB: begin req_o.a = 64'(cfg_i.q_bias); req_o.b = 64'(dt_q); end
      ST_DIV_K0:  begin req_o.is_div = 1'b1; req_o.a = 64'(paa_q); req_o.b = s_q; end
      ST_DIV_K1:  begin req_o.is_div = 1'b1; req_o.a = 64'(pba_q); req_o.b = s_q; end
      ST_COR_A:   begin req_o.sh32 = 1'b1; req_o.a = 64'(k0_q); req_o.b = 64'(y_q); end
      ST_COR_B:   begin req_o.sh32 = 1'b1; req_o.a = 64'(k1_q); req_o.b = 64'(y_q); end
      ST_COV_BA:  begin req_o.sh32 = 1'b1; req_o.a = 64'(k1_q); req_o.b = 64'(paa_q); end
      ST_COV_BB:  begin req_o.sh32 = 1'b1; req_o.a = 64'(k1_q); req_o.b = 64'(pab_q); end
      ST_COV_AA:  begin req_o.sh32 = 1'b1; req_o.a = 64'(k0_q); req_o.b = 64'(paa_q); end
      ST_COV_AB:  begin req_o.sh32 = 1'b1; req_o.a = 64'(k0_q); req_o.b = 64'(pab_q); end
      default:    op_w = 1'b0;
    endcase
    req_o.start = op_w & ~issued_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      issued_q  <= 1'b0;
      z_q       <= '0;
      w_q       <= '0;
      dt_q      <= '0;
      ang_q     <= '0;
      bias_q    <= '0;
      paa_q     <= '0;
      pab_q     <= '0;
      pba_q     <= '0;
      pbb_q     <= '0;
      m_q       <= '0;
      s_q       <= '0;
      k0_q      <= '0;
      k1_q      <= '0;
      y_q       <= '0;
      out_vld_q <= 1'b0;
      out_ang_q <= '0;
    end else begin
      if (out_vld_q && result_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (req_o.start) begin
        issued_q <= 1'b1;
      end
      if (rsp_i.done) begin
        issued_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (item_i.valid) begin
            z_q     <= item_i.measured_angle;
            w_q     <= item_i.measured_rate;
            dt_q    <= item_i.time_step;
            state_q <= ST_RATE;
          end
        end
        ST_RATE: begin
          if (rsp_i.done) begin
            ang_q   <= sat32(66'(ang_q) + res_w);
            state_q <= ST_PRED_M;
          end
        end
        ST_PRED_M: begin
          if (rsp_i.done) begin
            m_q     <= rsp_i.res;
            state_q <= ST_PRED_T;
          end
        end
        ST_PRED_T: begin
          if (rsp_i.done) begin
            paa_q   <= sat48(66'(paa_q) + res_w);
            pab_q   <= sat48(66'(pab_q) - 66'(m_q));
            pba_q   <= sat48(66'(pba_q) - 66'(m_q));
            state_q <= ST_PRED_QB;
          end
        end
        ST_PRED_QB: begin
          if (rsp_i.done) begin
            pbb_q   <= sat48(66'(pbb_q) + res_w);
            state_q <= ST_GAIN_S;
          end
        end
        ST_GAIN_S: begin
          s_q <= $signed(s_w[63:0]);
          y_q <= 33'(z_q) - 33'(ang_q);
          if (s_w == '0) begin
            k0_q    <= '0;
            k1_q    <= '0;
            state_q <= ST_COR_A;
          end else begin
            state_q <= ST_DIV_K0;
          end
        end
        ST_DIV_K0: begin
          if (rsp_i.done) begin
            k0_q    <= rsp_i.res[47:0];
            state_q <= ST_DIV_K1;
          end
        end
        ST_DIV_K1: begin
          if (rsp_i.done) begin
            k1_q    <= rsp_i.res[47:0];
            state_q <= ST_COR_A;
          end
        end
        ST_COR_A: begin
          if (rsp_i.done) begin
            ang_q   <= sat32(66'(ang_q) + res_w);
            state_q <= ST_COR_B;
          end
        end
        ST_COR_B: begin
          if (rsp_i.done) begin
            bias_q  <= sat32(66'(bias_q) + res_w);
            state_q <= ST_COV_BA;
          end
        end
        ST_COV_BA: begin
          if (rsp_i.done) begin
            pba_q   <= sat48(66'(pba_q) - res_w);
            state_q <= ST_COV_BB;
          end
        end
        ST_COV_BB: begin
          if (rsp_i.done) begin
            pbb_q   <= sat48(66'(pbb_q) - res_w);
            state_q <= ST_COV_AA;
          end
        end
        ST_COV_AA: begin
          if (rsp_i.done) begin
            paa_q   <= sat48(66'(paa_q) - res_w);
            state_q <= ST_COV_AB;
          end
        end
        ST_COV_AB: begin
          if (rsp_i.done) begin
            pab_q   <= sat48(66'(pab_q) - res_w);
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_vld_q || result_o.ready) begin
            out_vld_q <= 1'b1;
            out_ang_q <= ang_q;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/kab_checker.sv @@
// Port-level checks for the angle/bias Kalman filter, bound to the top level.
// Depends on kalman_angle_bias_filter_top.
module kab_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_angle_i,
  input logic        pready_i
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("ready stayed high after a word was accepted");

  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without processing");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_angle_i))
    else $error("stalled result word changed");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready_i)
    else $error("pready dropped");

endmodule

bind kalman_angle_bias_filter_top kab_checker u_kab_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (item_i.valid),
  .in_ready_i  (item_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_angle_i (result_o.filtered_angle),
  .pready_i    (pready)
);
